### hdl/tvcu_pkg.sv
// Shared constants, command codes and sine table function for the turtle command unit.
package tvcu_pkg;

   localparam int POS_BITS       = 16;
   localparam int ANGLE_BITS     = 16;
   localparam int TABLE_BITS     = 12;
   localparam int SINE_FRAC_BITS = 14;

   localparam int KIND_W     = 3;
   localparam int DIST_W     = 13;
   localparam int ANG_IN_W   = 16;
   localparam int TARGET_W   = 16;
   localparam int OUT_POS_W  = 16;
   localparam int OUT_ANG_W  = 16;
   localparam int SIZE_W     = 13;
   localparam int START_W    = 12;
   localparam int START_HD_W = 16;

   localparam int REQ_BITS   = DIST_W + ANG_IN_W + 2 * TARGET_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = 4 * OUT_POS_W + OUT_ANG_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam int QSTEPS    = 1 << (TABLE_BITS - 2);
   localparam int ROM_DEPTH = QSTEPS + 1;
   localparam int ROM_AW    = TABLE_BITS - 1;
   localparam int SINE_BITS = SINE_FRAC_BITS + 1;
   localparam int TRIG_W    = SINE_FRAC_BITS + 2;
   localparam int PROD_W    = DIST_W + TRIG_W;
   localparam int SUM_W     = (POS_BITS > 18 ? POS_BITS : 18) + 1;

   localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = {2'b01, {(ANGLE_BITS - 2){1'b0}}};
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Taylor series divisors (2k)*(2k+1) for k = 1..12
   localparam longint unsigned TAYLOR_DIV [1:12] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

   localparam logic signed [SUM_W-1:0] POS_HI =
      SUM_W'((longint'(1) <<< (POS_BITS - 1)) - longint'(1));
   localparam logic signed [SUM_W-1:0] POS_LO = -POS_HI - SUM_W'(1);
   localparam logic signed [PROD_W-1:0] ROUND_HALF =
      PROD_W'(longint'(1) <<< (SINE_FRAC_BITS - 1));

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [SIZE_W-1:0]     RST_SCREEN_WIDTH  = 13'd800;
   localparam logic [SIZE_W-1:0]     RST_SCREEN_HEIGHT = 13'd600;
   localparam logic [START_W-1:0]    RST_START_X       = 12'd0;
   localparam logic [START_W-1:0]    RST_START_Y       = 12'd0;
   localparam logic [START_HD_W-1:0] RST_START_HEADING = 16'd0;

   localparam logic signed [POS_BITS-1:0] RST_POS_X =
      POS_BITS'(RST_SCREEN_WIDTH / 2) + POS_BITS'(signed'(RST_START_X));
   localparam logic signed [POS_BITS-1:0] RST_POS_Y =
      POS_BITS'(RST_SCREEN_HEIGHT / 2) + POS_BITS'(signed'(RST_START_Y));
   localparam logic [ANGLE_BITS-1:0] RST_HEADING =
      ANGLE_BITS'(RST_START_HEADING) + QUARTER_TURN;

   typedef enum logic [KIND_W-1:0] {
      CMD_FORWARD     = 3'd0,
      CMD_PEN_DOWN    = 3'd1,
      CMD_PEN_UP      = 3'd2,
      CMD_LEFT        = 3'd3,
      CMD_RIGHT       = 3'd4,
      CMD_MOVE_TO     = 3'd5,
      CMD_SET_HEADING = 3'd6,
      CMD_HOME        = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_SCREEN_WIDTH  = 3'd0,
      CSR_SCREEN_HEIGHT = 3'd1,
      CSR_START_X       = 3'd2,
      CSR_START_Y       = 3'd3,
      CSR_START_HEADING = 3'd4
   } csr_reg_type;

   function automatic logic [SINE_BITS-1:0] sine_entry(input int unsigned i);
      longint unsigned theta;
      longint unsigned t2;
      longint unsigned term;
      longint          sum;
      longint unsigned rounded;
      theta = HALF_PI_Q30 * longint'(i) / QSTEPS;
      t2    = (theta * theta) >> 30;
      term  = theta;
      sum   = longint'(theta);
      for (int k = 1; k <= 12; k++) begin
         term = ((term * t2) >> 30) / TAYLOR_DIV[k];
         if (k % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (longint'(1) <<< 30)) begin
         sum = longint'(1) <<< 30;
      end
      rounded = (longint'(sum) + (longint'(1) <<< (29 - SINE_FRAC_BITS)))
                >> (30 - SINE_FRAC_BITS);
      return SINE_BITS'(rounded);
   endfunction

   function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      if (v > POS_HI) begin
         return POS_BITS'(POS_HI);
      end else if (v < POS_LO) begin
         return POS_BITS'(POS_LO);
      end
      return POS_BITS'(v);
   endfunction

endpackage

### hdl/turtle_vector_command_unit_core.sv
// Turtle command unit: heading and pen update, sine lookup, multiply, position update.
// rsp_tvalid rises once the accepted beat has passed the s1, s2, s3 and output registers.
// One command per cycle unless rsp_tready stalls; stages advance alone and fill bubbles.
// Heading and pen close their loop at accept, position closes its loop at the output stage.
// The sine ROM read takes a stage, and the two products share the next one.
// Reset: synchronous; registers 800/600/0/0/0, position 400,300, quarter turn, pen down.
module turtle_vector_command_unit_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // distance[12:0], turn_angle[28:13], target_x[44:29], target_y[60:45], zero pad
   input  logic [tvcu_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind[2:0]
   input  logic [tvcu_pkg::KIND_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // from_x[15:0], from_y[31:16], to_x[47:32], to_y[63:48], heading_now[79:64],
   // pen_now[80], zero pad
   output logic [tvcu_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // draw[0]
   output logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tvcu_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [tvcu_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [tvcu_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                              csr_pready
);
   import tvcu_pkg::*;

   typedef struct packed {
      cmd_type                      kind;
      logic signed [DIST_W-1:0]     fwd_len;
      logic [ANGLE_BITS-1:0]        heading;
      logic                         pen;
      logic                         draw;
      logic signed [POS_BITS-1:0]   abs_x;
      logic signed [POS_BITS-1:0]   abs_y;
   } cmd_stage_type;

   typedef struct packed {
      cmd_stage_type                cmd;
      logic                         sin_neg;
      logic                         cos_neg;
   } trig_stage_type;

   typedef struct packed {
      cmd_stage_type                cmd;
      logic signed [PROD_W-1:0]     prod_x;
      logic signed [PROD_W-1:0]     prod_y;
   } prod_stage_type;

   logic [SIZE_W-1:0]      width_ff;
   logic [SIZE_W-1:0]      height_ff;
   logic [START_W-1:0]     start_x_ff;
   logic [START_W-1:0]     start_y_ff;
   logic [START_HD_W-1:0]  start_hd_ff;
   logic                   csr_wr;
   csr_reg_type            csr_idx;

   logic [ANGLE_BITS-1:0]       heading_ff, heading_in;
   logic                        pen_ff, pen_in;
   logic signed [POS_BITS-1:0]  pos_x_ff, pos_x_in;
   logic signed [POS_BITS-1:0]  pos_y_ff, pos_y_in;

   logic            v1_ff, v2_ff, v3_ff, vo_ff;
   logic            rdy1, rdy2, rdy3, rdy_o;
   logic            req_accept;
   cmd_stage_type   s1_ff, s1_in;
   trig_stage_type  s2_ff, s2_in;
   prod_stage_type  s3_ff, s3_in;

   logic signed [DIST_W-1:0]    in_dist;
   logic [ANG_IN_W-1:0]         in_ang;
   logic signed [TARGET_W-1:0]  in_tx;
   logic signed [TARGET_W-1:0]  in_ty;
   logic signed [SUM_W-1:0]     half_w;
   logic signed [SUM_W-1:0]     half_h;

   logic [TABLE_BITS+ANGLE_BITS-1:0] idx_wide;
   logic [TABLE_BITS-1:0]       idx;
   logic [1:0]                  quad_s, quad_c;
   logic [TABLE_BITS-3:0]       frac;
   logic [ROM_AW-1:0]           addr_s, addr_c;
   logic [SINE_BITS-1:0]        mag_s, mag_c;
   logic signed [TRIG_W-1:0]    trig_s, trig_c;

   logic signed [PROD_W-1:0]    dx, dy;
   logic signed [SUM_W-1:0]     sum_x, sum_y;

   logic                          draw_ff;
   logic signed [OUT_POS_W-1:0]   from_x_ff, from_y_ff, to_x_ff, to_y_ff;
   logic [OUT_ANG_W-1:0]          heading_out_ff;
   logic                          pen_out_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_reg_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RST_SCREEN_WIDTH;
         height_ff   <= RST_SCREEN_HEIGHT;
         start_x_ff  <= RST_START_X;
         start_y_ff  <= RST_START_Y;
         start_hd_ff <= RST_START_HEADING;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_SCREEN_WIDTH:  width_ff    <= csr_pwdata[SIZE_W-1:0];
            CSR_SCREEN_HEIGHT: height_ff   <= csr_pwdata[SIZE_W-1:0];
            CSR_START_X:       start_x_ff  <= csr_pwdata[START_W-1:0];
            CSR_START_Y:       start_y_ff  <= csr_pwdata[START_W-1:0];
            CSR_START_HEADING: start_hd_ff <= csr_pwdata[START_HD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_SCREEN_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         CSR_SCREEN_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         CSR_START_X:       csr_prdata = CSR_DW'(start_x_ff);
         CSR_START_Y:       csr_prdata = CSR_DW'(start_y_ff);
         CSR_START_HEADING: csr_prdata = CSR_DW'(start_hd_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // stage handshake
   assign rdy_o      = !vo_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy_o;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdy1)  v1_ff <= req_tvalid;
         if (rdy2)  v2_ff <= v1_ff;
         if (rdy3)  v3_ff <= v2_ff;
         if (rdy_o) vo_ff <= v3_ff;
      end
   end

   // accept stage: heading and pen, absolute targets
   assign in_dist = req_tdata[DIST_W-1:0];
   assign in_ang  = req_tdata[DIST_W +: ANG_IN_W];
   assign in_tx   = req_tdata[DIST_W + ANG_IN_W +: TARGET_W];
   assign in_ty   = req_tdata[DIST_W + ANG_IN_W + TARGET_W +: TARGET_W];
   assign half_w  = signed'(SUM_W'(width_ff >> 1));
   assign half_h  = signed'(SUM_W'(height_ff >> 1));

   always_comb begin
      heading_in     = heading_ff;
      pen_in         = pen_ff;
      s1_in.kind     = cmd_type'(req_tuser);
      s1_in.fwd_len  = in_dist;
      s1_in.abs_x    = pos_x_ff;
      s1_in.abs_y    = pos_y_ff;
      unique case (cmd_type'(req_tuser))
         CMD_PEN_DOWN:    pen_in = 1'b1;
         CMD_PEN_UP:      pen_in = 1'b0;
         CMD_LEFT:        heading_in = heading_ff + ANGLE_BITS'(in_ang);
         CMD_RIGHT:       heading_in = heading_ff - ANGLE_BITS'(in_ang);
         CMD_SET_HEADING: heading_in = ANGLE_BITS'(in_ang) + QUARTER_TURN;
         CMD_MOVE_TO: begin
            s1_in.abs_x = sat_pos(SUM_W'(in_tx) + half_w);
            s1_in.abs_y = sat_pos(half_h - SUM_W'(in_ty));
         end
         CMD_HOME: begin
            heading_in  = ANGLE_BITS'(start_hd_ff) + QUARTER_TURN;
            pen_in      = 1'b1;
            s1_in.abs_x = sat_pos(SUM_W'(signed'(start_x_ff)) + half_w);
            s1_in.abs_y = sat_pos(SUM_W'(signed'(start_y_ff)) + half_h);
         end
         default: ;
      endcase
      s1_in.heading = heading_in;
      s1_in.pen     = pen_in;
      s1_in.draw    = pen_ff && (cmd_type'(req_tuser) == CMD_FORWARD ||
                                 cmd_type'(req_tuser) == CMD_MOVE_TO);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= RST_HEADING;
         pen_ff     <= 1'b1;
      end else if (req_accept) begin
         heading_ff <= heading_in;
         pen_ff     <= pen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) s1_ff <= s1_in;
   end

   // table stage: quadrant fold and ROM read
   assign idx_wide = {s1_ff.heading, {TABLE_BITS{1'b0}}};
   assign idx      = idx_wide[TABLE_BITS+ANGLE_BITS-1 -: TABLE_BITS];
   assign quad_s   = idx[TABLE_BITS-1 -: 2];
   assign quad_c   = quad_s + 2'd1;
   assign frac     = idx[TABLE_BITS-3:0];
   assign addr_s   = quad_s[0] ? ROM_AW'(QSTEPS) - ROM_AW'(frac) : ROM_AW'(frac);
   assign addr_c   = quad_c[0] ? ROM_AW'(QSTEPS) - ROM_AW'(frac) : ROM_AW'(frac);

   tvcu_sine_rom u_rom (
      .clock     (clock),
      .rd_en     (rdy2),
      .addr_a    (addr_s),
      .addr_b    (addr_c),
      .data_a_ff (mag_s),
      .data_b_ff (mag_c)
   );

   assign s2_in.cmd     = s1_ff;
   assign s2_in.sin_neg = quad_s[1];
   assign s2_in.cos_neg = quad_c[1];

   always_ff @(posedge clock) begin
      if (rdy2) s2_ff <= s2_in;
   end

   // multiply stage
   assign trig_s = s2_ff.sin_neg ? -signed'(TRIG_W'(mag_s)) : signed'(TRIG_W'(mag_s));
   assign trig_c = s2_ff.cos_neg ? -signed'(TRIG_W'(mag_c)) : signed'(TRIG_W'(mag_c));

   assign s3_in.cmd    = s2_ff.cmd;
   assign s3_in.prod_x = PROD_W'(s2_ff.cmd.fwd_len) * PROD_W'(trig_c);
   assign s3_in.prod_y = PROD_W'(s2_ff.cmd.fwd_len) * PROD_W'(trig_s);

   always_ff @(posedge clock) begin
      if (rdy3) s3_ff <= s3_in;
   end

   // position stage: round, accumulate and saturate, or load the absolute target
   assign dx    = (s3_ff.prod_x + ROUND_HALF) >>> SINE_FRAC_BITS;
   assign dy    = (s3_ff.prod_y + ROUND_HALF) >>> SINE_FRAC_BITS;
   assign sum_x = SUM_W'(pos_x_ff) + SUM_W'(dx);
   assign sum_y = SUM_W'(pos_y_ff) - SUM_W'(dy);

   always_comb begin
      case (s3_ff.cmd.kind) inside
         CMD_FORWARD: begin
            pos_x_in = sat_pos(sum_x);
            pos_y_in = sat_pos(sum_y);
         end
         CMD_MOVE_TO, CMD_HOME: begin
            pos_x_in = s3_ff.cmd.abs_x;
            pos_y_in = s3_ff.cmd.abs_y;
         end
         default: begin
            pos_x_in = pos_x_ff;
            pos_y_in = pos_y_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= RST_POS_X;
         pos_y_ff <= RST_POS_Y;
      end else if (v3_ff && rdy_o) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_o) begin
         draw_ff        <= s3_ff.cmd.draw;
         from_x_ff      <= OUT_POS_W'(pos_x_ff);
         from_y_ff      <= OUT_POS_W'(pos_y_ff);
         to_x_ff        <= OUT_POS_W'(pos_x_in);
         to_y_ff        <= OUT_POS_W'(pos_y_in);
         heading_out_ff <= OUT_ANG_W'(s3_ff.cmd.heading);
         pen_out_ff     <= s3_ff.cmd.pen;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tuser  = draw_ff;
   assign rsp_tdata  = RSP_DATA_W'({pen_out_ff, heading_out_ff, to_y_ff, to_x_ff,
                                    from_y_ff, from_x_ff});

`ifndef ASSERT_OFF
   a_draw_pen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> pen_out_ff)
      else $error("draw beat with pen up");

   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !(v3_ff && rdy_o) |=> $stable(pos_x_ff) && $stable(pos_y_ff))
      else $error("position changed without a command leaving the pipe");

   a_heading_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(heading_ff) && $stable(pen_ff))
      else $error("heading or pen changed without an accepted beat");
`endif

endmodule

### hdl/tvcu_sine_rom.sv
// Quarter-wave sine ROM with two registered read ports.
module tvcu_sine_rom (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [tvcu_pkg::ROM_AW-1:0]     addr_a,
   input  logic [tvcu_pkg::ROM_AW-1:0]     addr_b,
   output logic [tvcu_pkg::SINE_BITS-1:0]  data_a_ff,
   output logic [tvcu_pkg::SINE_BITS-1:0]  data_b_ff
);
   import tvcu_pkg::*;

   logic [SINE_BITS-1:0] rom [0:ROM_DEPTH-1];

   for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
      assign rom[g] = sine_entry(g);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= rom[addr_a];
         data_b_ff <= rom[addr_b];
      end
   end

endmodule
